FILE: rtl/ckcc_pkg.sv
// Shared types and constants for the color key column centroid block.
`timescale 1ns / 1ps

package ckcc_pkg;

  // Fixed field widths
  localparam int unsigned DIM_CFG_W   = 11;
  localparam int unsigned CHAN_W      = 8;
  localparam int unsigned LIMIT_W     = 10;
  localparam int unsigned FOV_W       = 16;
  localparam int unsigned ANGLE_W     = 16;
  localparam int unsigned COUNT_OUT_W = 21;

  // Stream payload widths
  localparam int unsigned IN_DATA_W   = 3 * CHAN_W;
  localparam int unsigned OUT_BITS    = 1 + ANGLE_W + COUNT_OUT_W;
  localparam int unsigned OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;

  // Configuration port
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_VIEW_ANGLE   = 3'd2,
    REG_REF_FIRST    = 3'd3,
    REG_REF_SECOND   = 3'd4,
    REG_REF_THIRD    = 3'd5,
    REG_MATCH_LIMIT  = 3'd6
  } cfg_reg_e;

  // Register reset values
  localparam logic [DIM_CFG_W-1:0] RST_FRAME_WIDTH  = 11'd256;
  localparam logic [DIM_CFG_W-1:0] RST_FRAME_HEIGHT = 11'd128;
  localparam logic [FOV_W-1:0]     RST_VIEW_ANGLE   = 16'd4096;
  localparam logic [CHAN_W-1:0]    RST_REF_FIRST    = 8'd95;
  localparam logic [CHAN_W-1:0]    RST_REF_SECOND   = 8'd187;
  localparam logic [CHAN_W-1:0]    RST_REF_THIRD    = 8'd203;
  localparam logic [LIMIT_W-1:0]   RST_MATCH_LIMIT  = 10'd30;

  // Saturation bounds of the angle
  localparam logic [ANGLE_W-1:0] ANGLE_MIN = 16'h8000;
  localparam logic [ANGLE_W-1:0] ANGLE_MAX = 16'h7FFF;

  // Color key settings seen by the pixel stage
  typedef struct packed {
    logic [CHAN_W-1:0]  ref_first;
    logic [CHAN_W-1:0]  ref_second;
    logic [CHAN_W-1:0]  ref_third;
    logic [LIMIT_W-1:0] limit;
  } ckcc_key_t;

  // One frame result
  typedef struct packed {
    logic                      found;
    logic signed [ANGLE_W-1:0] angle;
    logic [COUNT_OUT_W-1:0]    count;
  } ckcc_result_t;

endpackage

FILE: rtl/ckcc_pixel.sv
// Per-pixel color match, raster position counters and frame accumulators.
`timescale 1ns / 1ps

module ckcc_pixel import ckcc_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  localparam int unsigned WW   = $clog2(MAX_WIDTH + 1),
  localparam int unsigned HW   = $clog2(MAX_HEIGHT + 1),
  localparam int unsigned CPW  = $clog2(MAX_WIDTH),
  localparam int unsigned CNTW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1),
  localparam int unsigned SW   = CPW + CNTW
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pix_accept_i,
  input  logic [CHAN_W-1:0] chan_first_i,
  input  logic [CHAN_W-1:0] chan_second_i,
  input  logic [CHAN_W-1:0] chan_third_i,
  input  ckcc_key_t         key_i,
  input  logic [WW-1:0]     width_i,
  input  logic [HW-1:0]     height_i,
  output logic              frame_end_o,
  output logic [SW-1:0]     col_sum_o,
  output logic [CNTW-1:0]   match_cnt_o
);

  localparam int unsigned RPW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  logic [CPW-1:0]     col_q, col_d;
  logic [RPW-1:0]     row_q, row_d;
  logic [SW-1:0]      sum_q, sum_d;
  logic [CNTW-1:0]    cnt_q, cnt_d;
  logic [LIMIT_W-1:0] color_diff;
  logic               match;
  logic               row_end;
  logic               frame_end;
  logic [SW-1:0]      sum_acc;
  logic [CNTW-1:0]    cnt_acc;

  // Sum of absolute channel differences against the key color
  assign color_diff = LIMIT_W'(abs_diff(chan_first_i, key_i.ref_first))
                    + LIMIT_W'(abs_diff(chan_second_i, key_i.ref_second))
                    + LIMIT_W'(abs_diff(chan_third_i, key_i.ref_third));
  assign match = color_diff < key_i.limit;

  // Totals including the current pixel
  assign sum_acc = match ? sum_q + SW'(col_q) : sum_q;
  assign cnt_acc = match ? cnt_q + CNTW'(1) : cnt_q;

  // Row and frame boundaries
  assign row_end   = WW'(col_q) >= (width_i - WW'(1));
  assign frame_end = row_end && (HW'(row_q) >= (height_i - HW'(1)));

  // Advance position and accumulators on each transaction
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (pix_accept_i) begin
      sum_d = sum_acc;
      cnt_d = cnt_acc;
      if (row_end) begin
        col_d = '0;
        if (frame_end) begin
          row_d = '0;
          sum_d = '0;
          cnt_d = '0;
        end else begin
          row_d = row_q + RPW'(1);
        end
      end else begin
        col_d = col_q + CPW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      sum_q <= '0;
      cnt_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

  // Hand the frame totals to the angle sequencer
  assign frame_end_o = pix_accept_i && frame_end;
  assign col_sum_o   = sum_acc;
  assign match_cnt_o = cnt_acc;

endmodule

FILE: rtl/ckcc_angle.sv
// Angle sequencer: shift-add multiply and restoring divide on one shared adder.
`timescale 1ns / 1ps

module ckcc_angle import ckcc_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  localparam int unsigned WW   = $clog2(MAX_WIDTH + 1),
  localparam int unsigned CPW  = $clog2(MAX_WIDTH),
  localparam int unsigned CNTW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1),
  localparam int unsigned SW   = CPW + CNTW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SW-1:0]    col_sum_i,
  input  logic [CNTW-1:0]  match_cnt_i,
  input  logic [WW-1:0]    width_i,
  input  logic [FOV_W-1:0] fov_i,
  output logic             busy_o,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output ckcc_result_t     res_o
);

  // Product count*width, and the accumulator that holds the offset numerator
  localparam int unsigned PW  = CNTW + WW;
  localparam int unsigned AW  = PW + ANGLE_W + 3;
  localparam int unsigned MW  = (WW > FOV_W) ? WW : FOV_W;
  localparam int unsigned MCW = $clog2(MW);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_CW,
    S_DIFF,
    S_MUL_FOV,
    S_ADD_P,
    S_ADD_P_HI,
    S_CHECK,
    S_CHECK_HI,
    S_DIV,
    S_DONE
  } state_e;

  state_e             state_q;
  logic [AW-1:0]      acc_q;
  logic [AW-1:0]      opnd_q;
  logic [PW-1:0]      prod_q;
  logic [SW-1:0]      sum_q;
  logic [CNTW-1:0]    cnt_q;
  logic [MW-1:0]      mult_q;
  logic [MCW-1:0]     step_q;
  logic [ANGLE_W-1:0] quo_q;
  ckcc_result_t       res_q;

  logic [AW-1:0]      add_a;
  logic [AW-1:0]      add_b;
  logic               add_sub;
  logic [AW-1:0]      add_sum;
  logic               add_neg;

  // Shared add/subtract unit, operands picked by state
  always_comb begin
    add_a   = acc_q;
    add_b   = opnd_q;
    add_sub = 1'b0;
    case (state_q)
      S_MUL_CW, S_MUL_FOV: begin
        add_a = {acc_q[AW-2:0], 1'b0};
        add_b = mult_q[MW-1] ? opnd_q : '0;
      end
      S_DIFF: begin
        add_a   = AW'({sum_q, 1'b0});
        add_b   = AW'(prod_q);
        add_sub = 1'b1;
      end
      S_ADD_P: begin
        add_b = AW'(prod_q);
      end
      S_ADD_P_HI: begin
        add_b = AW'({prod_q, {ANGLE_W{1'b0}}});
      end
      S_CHECK_HI, S_DIV: begin
        add_sub = 1'b1;
      end
      default: ;
    endcase
    add_sum = add_a + (add_sub ? ~add_b : add_b) + AW'(add_sub);
  end

  assign add_neg = add_sum[AW-1];

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      acc_q   <= '0;
      opnd_q  <= '0;
      prod_q  <= '0;
      sum_q   <= '0;
      cnt_q   <= '0;
      mult_q  <= '0;
      step_q  <= '0;
      quo_q   <= '0;
      res_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            sum_q <= col_sum_i;
            cnt_q <= match_cnt_i;
            if (match_cnt_i == '0) begin
              res_q   <= '0;
              state_q <= S_DONE;
            end else begin
              acc_q   <= '0;
              opnd_q  <= AW'(match_cnt_i);
              mult_q  <= MW'(width_i);
              step_q  <= MCW'(MW - 1);
              state_q <= S_MUL_CW;
            end
          end
        end
        // count * width, MSB first
        S_MUL_CW: begin
          acc_q  <= add_sum;
          prod_q <= add_sum[PW-1:0];
          mult_q <= {mult_q[MW-2:0], 1'b0};
          step_q <= step_q - MCW'(1);
          if (step_q == '0) begin
            state_q <= S_DIFF;
          end
        end
        // 2*sum - count*width becomes the multiplicand
        S_DIFF: begin
          opnd_q  <= add_sum;
          acc_q   <= '0;
          mult_q  <= MW'(fov_i);
          step_q  <= MCW'(MW - 1);
          state_q <= S_MUL_FOV;
        end
        // fov * difference, signed in two's complement
        S_MUL_FOV: begin
          acc_q  <= add_sum;
          mult_q <= {mult_q[MW-2:0], 1'b0};
          step_q <= step_q - MCW'(1);
          if (step_q == '0) begin
            state_q <= S_ADD_P;
          end
        end
        // Add half the divisor for rounding
        S_ADD_P: begin
          acc_q   <= add_sum;
          state_q <= S_ADD_P_HI;
        end
        // Offset the quotient by half its range so it stays unsigned
        S_ADD_P_HI: begin
          acc_q   <= add_sum;
          state_q <= S_CHECK;
        end
        // Below the range: saturate low
        S_CHECK: begin
          if (acc_q[AW-1]) begin
            res_q   <= '{found: 1'b1, angle: ANGLE_MIN, count: COUNT_OUT_W'(cnt_q)};
            state_q <= S_DONE;
          end else begin
            opnd_q  <= AW'({prod_q, {(ANGLE_W + 1){1'b0}}});
            state_q <= S_CHECK_HI;
          end
        end
        // Above the range: saturate high
        S_CHECK_HI: begin
          if (!add_neg) begin
            res_q   <= '{found: 1'b1, angle: ANGLE_MAX, count: COUNT_OUT_W'(cnt_q)};
            state_q <= S_DONE;
          end else begin
            opnd_q  <= AW'({prod_q, {ANGLE_W{1'b0}}});
            quo_q   <= '0;
            step_q  <= MCW'(ANGLE_W - 1);
            state_q <= S_DIV;
          end
        end
        // Restoring divide, one quotient bit per cycle
        S_DIV: begin
          if (!add_neg) begin
            acc_q <= add_sum;
          end
          quo_q  <= {quo_q[ANGLE_W-2:0], ~add_neg};
          opnd_q <= {1'b0, opnd_q[AW-1:1]};
          step_q <= step_q - MCW'(1);
          if (step_q == '0) begin
            res_q   <= '{found: 1'b1,
                         angle: {~quo_q[ANGLE_W-2], quo_q[ANGLE_W-3:0], ~add_neg},
                         count: COUNT_OUT_W'(cnt_q)};
            state_q <= S_DONE;
          end
        end
        // Hold the result until the output stage takes it
        S_DONE: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o      = state_q != S_IDLE;
  assign res_valid_o = state_q == S_DONE;
  assign res_o       = res_q;

endmodule

FILE: rtl/color_key_column_centroid.sv
// Top level of the color key column centroid block.
`timescale 1ns / 1ps

// Color key column centroid. Pixels stream in raster order, one per clock,
// packed as first, second and third color byte from the low bits up. A pixel
// matches when the summed absolute difference from the reference color is
// below match_limit; matched columns and the match count are summed over the
// frame. After the last pixel of a frame one result leaves on the master
// stream: found, the steering angle (mean column / width - 0.5) * fov in
// signed Q4.12 (rounded, saturated), and the match count. While the result is
// computed the slave side is not ready: the end-of-frame work runs on one
// shared adder, a multiply of count by width and of fov by the offset sum,
// then a 16-step divide; a frame with no match skips the arithmetic. A
// finished result moves into the output register; the slave side stays not
// ready beyond that only while an earlier result still waits there untaken.
// Registers are written over the plain write port; frame dimensions of zero
// act as one and values above MAX_WIDTH or MAX_HEIGHT act as the maximum.
module color_key_column_centroid import ckcc_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Pixel stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // chan_first, chan_second, chan_third
  // Result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata   // found, steer_angle_q12, matched_pixels
);

  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned CPW   = $clog2(MAX_WIDTH);
  localparam int unsigned CNTW  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int unsigned SW    = CPW + CNTW;
  localparam int unsigned WCMPW = (WW > DIM_CFG_W) ? WW : DIM_CFG_W;
  localparam int unsigned HCMPW = (HW > DIM_CFG_W) ? HW : DIM_CFG_W;

  logic [DIM_CFG_W-1:0] frame_width_q;
  logic [DIM_CFG_W-1:0] frame_height_q;
  logic [FOV_W-1:0]     view_angle_q;
  ckcc_key_t            key_q;

  logic [WW-1:0]        width_c;
  logic [HW-1:0]        height_c;
  logic                 pix_accept;
  logic                 frame_end;
  logic [SW-1:0]        col_sum;
  logic [CNTW-1:0]      match_cnt;
  logic                 busy;
  logic                 res_valid;
  logic                 res_ready;
  ckcc_result_t         res;

  logic                 out_valid_q;
  ckcc_result_t         out_data_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q    <= RST_FRAME_WIDTH;
      frame_height_q   <= RST_FRAME_HEIGHT;
      view_angle_q     <= RST_VIEW_ANGLE;
      key_q.ref_first  <= RST_REF_FIRST;
      key_q.ref_second <= RST_REF_SECOND;
      key_q.ref_third  <= RST_REF_THIRD;
      key_q.limit      <= RST_MATCH_LIMIT;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_FRAME_WIDTH:  frame_width_q    <= cfg_data_i[DIM_CFG_W-1:0];
        REG_FRAME_HEIGHT: frame_height_q   <= cfg_data_i[DIM_CFG_W-1:0];
        REG_VIEW_ANGLE:   view_angle_q     <= cfg_data_i[FOV_W-1:0];
        REG_REF_FIRST:    key_q.ref_first  <= cfg_data_i[CHAN_W-1:0];
        REG_REF_SECOND:   key_q.ref_second <= cfg_data_i[CHAN_W-1:0];
        REG_REF_THIRD:    key_q.ref_third  <= cfg_data_i[CHAN_W-1:0];
        REG_MATCH_LIMIT:  key_q.limit      <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp frame dimensions to [1, max]
  always_comb begin
    if (frame_width_q == '0) begin
      width_c = WW'(1);
    end else if (WCMPW'(frame_width_q) > WCMPW'(MAX_WIDTH)) begin
      width_c = WW'(MAX_WIDTH);
    end else begin
      width_c = WW'(frame_width_q);
    end
    if (frame_height_q == '0) begin
      height_c = HW'(1);
    end else if (HCMPW'(frame_height_q) > HCMPW'(MAX_HEIGHT)) begin
      height_c = HW'(MAX_HEIGHT);
    end else begin
      height_c = HW'(frame_height_q);
    end
  end

  assign s_axis_tready = !busy;
  assign pix_accept    = s_axis_tvalid && s_axis_tready;

  ckcc_pixel #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_pixel (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pix_accept_i  (pix_accept),
    .chan_first_i  (s_axis_tdata[CHAN_W-1:0]),
    .chan_second_i (s_axis_tdata[2*CHAN_W-1:CHAN_W]),
    .chan_third_i  (s_axis_tdata[3*CHAN_W-1:2*CHAN_W]),
    .key_i         (key_q),
    .width_i       (width_c),
    .height_i      (height_c),
    .frame_end_o   (frame_end),
    .col_sum_o     (col_sum),
    .match_cnt_o   (match_cnt)
  );

  ckcc_angle #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_angle (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (frame_end),
    .col_sum_i   (col_sum),
    .match_cnt_i (match_cnt),
    .width_i     (width_c),
    .fov_i       (view_angle_q),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register: load when empty or being drained
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
      out_data_q  <= res;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'({out_data_q.count, out_data_q.angle, out_data_q.found});

endmodule

FILE: tb/sv/tb_color_key_column_centroid.sv
// Self-checking testbench for the color key column centroid block.
`timescale 1ns / 1ps

module tb_color_key_column_centroid import ckcc_pkg::*; ();

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 7;
  localparam int MAX_W          = 1024;
  localparam int MAX_H          = 1024;
  localparam int SETTLE_CYCLES  = 80;   // above the worst end-of-frame latency
  localparam int DRAIN_CYCLES   = 80;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int WIDE_PIXELS    = 200;
  localparam int TALL_PIXELS    = 100;
  localparam int RANDOM_PIXELS  = 560;

  // Index past the register list; writes to it must be ignored
  localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED = 3'd7;

  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_PIXEL,
    ROW_PIXEL_KNOWN
  } row_kind_e;

  typedef struct packed {
    row_kind_e               kind;
    logic [CFG_ADDR_W-1:0]   addr;
    logic [CFG_DATA_W-1:0]   value;
    logic [IN_DATA_W-1:0]    pixel;
    ckcc_result_t            want;
  } opening_row_t;

  localparam ckcc_result_t NO_RESULT = '0;

  // Opening sequence: single-pixel frames first so each result reads off directly,
  // then two three-column frames with an exact-match key checked by the predictor.
  localparam opening_row_t OPENING_ROWS [31] = '{
    '{ROW_WRITE,       REG_FRAME_WIDTH,  16'd1,     24'h0,      NO_RESULT},
    '{ROW_WRITE,       REG_FRAME_HEIGHT, 16'd1,     24'h0,      NO_RESULT},
    '{ROW_PIXEL_KNOWN, REG_FRAME_WIDTH,  16'd0,     24'hCBBB5F, '{1'b1, 16'hF800, 21'd1}},
    '{ROW_PIXEL_KNOWN, REG_FRAME_WIDTH,  16'd0,     24'h000000, NO_RESULT},
    '{ROW_PIXEL_KNOWN, REG_FRAME_WIDTH,  16'd0,     24'hFFFFFF, NO_RESULT},
    '{ROW_WRITE,       REG_MATCH_LIMIT,  16'd0,     24'h0,      NO_RESULT},
    '{ROW_PIXEL_KNOWN, REG_FRAME_WIDTH,  16'd0,     24'hCBBB5F, NO_RESULT},
    '{ROW_WRITE,       REG_MATCH_LIMIT,  16'd766,   24'h0,      NO_RESULT},
    '{ROW_PIXEL_KNOWN, REG_FRAME_WIDTH,  16'd0,     24'h00FF00, '{1'b1, 16'hF800, 21'd1}},
    '{ROW_WRITE,       REG_MATCH_LIMIT,  16'd1023,  24'h0,      NO_RESULT},
    '{ROW_PIXEL_KNOWN, REG_FRAME_WIDTH,  16'd0,     24'hFF00FF, '{1'b1, 16'hF800, 21'd1}},
    '{ROW_WRITE,       REG_VIEW_ANGLE,   16'd0,     24'h0,      NO_RESULT},
    '{ROW_PIXEL_KNOWN, REG_FRAME_WIDTH,  16'd0,     24'h123456, '{1'b1, 16'h0000, 21'd1}},
    '{ROW_WRITE,       REG_VIEW_ANGLE,   16'hFFFF,  24'h0,      NO_RESULT},
    '{ROW_PIXEL_KNOWN, REG_FRAME_WIDTH,  16'd0,     24'hFEDCBA, '{1'b1, 16'h8001, 21'd1}},
    '{ROW_WRITE,       REG_FRAME_WIDTH,  16'd0,     24'h0,      NO_RESULT},
    '{ROW_PIXEL_KNOWN, REG_FRAME_WIDTH,  16'd0,     24'h0F0F0F, '{1'b1, 16'h8001, 21'd1}},
    '{ROW_WRITE,       REG_UNMAPPED,     16'd3,     24'h0,      NO_RESULT},
    '{ROW_PIXEL_KNOWN, REG_FRAME_WIDTH,  16'd0,     24'hA5A5A5, '{1'b1, 16'h8001, 21'd1}},
    '{ROW_WRITE,       REG_FRAME_WIDTH,  16'd3,     24'h0,      NO_RESULT},
    '{ROW_WRITE,       REG_FRAME_HEIGHT, 16'd0,     24'h0,      NO_RESULT},
    '{ROW_WRITE,       REG_REF_FIRST,    16'h00,    24'h0,      NO_RESULT},
    '{ROW_WRITE,       REG_REF_SECOND,   16'hFF,    24'h0,      NO_RESULT},
    '{ROW_WRITE,       REG_REF_THIRD,    16'h80,    24'h0,      NO_RESULT},
    '{ROW_WRITE,       REG_MATCH_LIMIT,  16'd1,     24'h0,      NO_RESULT},
    '{ROW_PIXEL,       REG_FRAME_WIDTH,  16'd0,     24'h80FF00, NO_RESULT},
    '{ROW_PIXEL,       REG_FRAME_WIDTH,  16'd0,     24'h80FF01, NO_RESULT},
    '{ROW_PIXEL,       REG_FRAME_WIDTH,  16'd0,     24'h80FF00, NO_RESULT},
    '{ROW_PIXEL,       REG_FRAME_WIDTH,  16'd0,     24'hFFFFFF, NO_RESULT},
    '{ROW_PIXEL,       REG_FRAME_WIDTH,  16'd0,     24'h80FF00, NO_RESULT},
    '{ROW_PIXEL,       REG_FRAME_WIDTH,  16'd0,     24'h000000, NO_RESULT}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_ADDR_W-1:0] cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;   // chan_first, chan_second, chan_third
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // found, steer_angle_q12, matched_pixels

  color_key_column_centroid #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Predictor copy of the key settings and the frame accumulators
  logic [DIM_CFG_W-1:0] key_width;
  logic [DIM_CFG_W-1:0] key_height;
  logic [FOV_W-1:0]     key_fov;
  logic [CHAN_W-1:0]    key_ref_first;
  logic [CHAN_W-1:0]    key_ref_second;
  logic [CHAN_W-1:0]    key_ref_third;
  logic [LIMIT_W-1:0]   key_limit;
  int unsigned          col_pos;
  int unsigned          row_pos;
  longint               col_sum;
  int unsigned          hit_count;

  ckcc_result_t expected_frames[$];

  int  mismatches;
  int  frames_checked;
  int  pixels_sent;
  int  register_writes;
  int  quiet_cycles;
  bit  stream_busy;
  bit  tx_gaps_on;
  bit  rx_stalls_on;
  bit  hold_request;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic int unsigned abs_diff(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? int'(a - b) : int'(b - a);
  endfunction

  function automatic void apply_register(input logic [CFG_ADDR_W-1:0] addr,
                                         input logic [CFG_DATA_W-1:0] value);
    case (addr)
      REG_FRAME_WIDTH:  key_width      = value[DIM_CFG_W-1:0];
      REG_FRAME_HEIGHT: key_height     = value[DIM_CFG_W-1:0];
      REG_VIEW_ANGLE:   key_fov        = value[FOV_W-1:0];
      REG_REF_FIRST:    key_ref_first  = value[CHAN_W-1:0];
      REG_REF_SECOND:   key_ref_second = value[CHAN_W-1:0];
      REG_REF_THIRD:    key_ref_third  = value[CHAN_W-1:0];
      REG_MATCH_LIMIT:  key_limit      = value[LIMIT_W-1:0];
      default: ;
    endcase
  endfunction

  // Accumulate one pixel; return 1 with the frame result when it closes the frame
  function automatic bit centroid_after_pixel(input logic [IN_DATA_W-1:0] px,
                                              output ckcc_result_t res);
    int unsigned w;
    int unsigned h;
    int unsigned diff;
    longint      cw;
    longint      num;
    longint      den;
    longint      n;
    longint      d;
    longint      q;
    res  = '0;
    w    = (key_width == 0) ? 1 : ((key_width > MAX_W) ? MAX_W : int'(key_width));
    h    = (key_height == 0) ? 1 : ((key_height > MAX_H) ? MAX_H : int'(key_height));
    diff = abs_diff(px[7:0], key_ref_first) + abs_diff(px[15:8], key_ref_second)
         + abs_diff(px[23:16], key_ref_third);
    if (diff < key_limit) begin
      col_sum   += col_pos;
      hit_count += 1;
    end
    // Advance the raster position; only the last pixel of a frame goes on
    if (col_pos < w - 1) begin
      col_pos += 1;
      return 1'b0;
    end
    col_pos = 0;
    if (row_pos < h - 1) begin
      row_pos += 1;
      return 1'b0;
    end
    row_pos = 0;
    if (hit_count != 0) begin
      // angle = fov * (2S - C*W) / (2*C*W), rounded half up, saturated
      cw  = longint'(hit_count) * longint'(w);
      num = longint'(key_fov) * (2 * col_sum - cw);
      den = 2 * cw;
      n   = 2 * num + den;
      d   = 2 * den;
      q   = (n >= 0) ? n / d : -((-n + d - 1) / d);
      if (q > 32767)  q = 32767;
      if (q < -32768) q = -32768;
      res.found = 1'b1;
      res.angle = q[ANGLE_W-1:0];
      res.count = hit_count[COUNT_OUT_W-1:0];
    end
    col_sum   = 0;
    hit_count = 0;
    return 1'b1;
  endfunction

  function automatic int idle_length();
    return ($urandom_range(0, 6) == 0) ? int'($urandom_range(8, 40))
                                       : int'($urandom_range(1, 3));
  endfunction

  // Set random bits above the register width now and then; they must be dropped
  function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CFG_DATA_W-1:0] value,
                                                      input int w);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    if ($urandom_range(0, 3) == 0) return value | (junk << w);
    return value;
  endfunction

  // Pixel near the key color, or anywhere in the color cube
  function automatic logic [IN_DATA_W-1:0] make_pixel(input bit near);
    logic [IN_DATA_W-1:0] px;
    logic [CHAN_W-1:0]    base;
    int                   v;
    px = IN_DATA_W'($urandom);
    if (near) begin
      for (int i = 0; i < 3; i++) begin
        base = (i == 0) ? key_ref_first : ((i == 1) ? key_ref_second : key_ref_third);
        v = int'(base) + int'($urandom_range(0, 40)) - 20;
        if (v < 0)   v = 0;
        if (v > 255) v = 255;
        px[8*i +: 8] = v[7:0];
      end
    end
    return px;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("[%0t] result %0d: %s is %0d, expected %0d", $time, frames_checked, what,
             got, want);
  endtask

  // Drain outstanding results and end-of-frame work before touching registers
  task automatic settle_for_write();
    if (stream_busy) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      while (expected_frames.size() != 0) @(posedge clk_i);
      repeat (SETTLE_CYCLES) @(posedge clk_i);
      stream_busy = 1'b0;
    end
  endtask

  task automatic write_register(input logic [CFG_ADDR_W-1:0] addr,
                                input logic [CFG_DATA_W-1:0] value);
    settle_for_write();
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_addr_i = addr;
    cfg_data_i = value;
    apply_register(addr, value);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    register_writes++;
  endtask

  // Offer one pixel, wait for the transaction, then record what it should produce
  task automatic send_pixel(input logic [IN_DATA_W-1:0] px, input bit known,
                            input ckcc_result_t known_res);
    int           gap;
    ckcc_result_t res;
    gap = (tx_gaps_on && $urandom_range(0, 3) == 0) ? idle_length() : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = px;
    do @(posedge clk_i); while (!s_axis_tready);
    if (centroid_after_pixel(px, res)) expected_frames.push_back(known ? known_res : res);
    pixels_sent++;
    stream_busy = 1'b1;
  endtask

  task automatic draw_key_settings();
    int unsigned           pick;
    int unsigned           width;
    int unsigned           limit;
    logic [CFG_DATA_W-1:0] fov;
    pick = $urandom_range(0, 9);
    if (pick == 0)      width = 0;
    else if (pick == 1) width = 1;
    else if (pick == 9) width = $urandom_range(13, 40);
    else                width = $urandom_range(2, 12);
    pick = $urandom_range(0, 9);
    if (pick == 0)      limit = 0;
    else if (pick == 1) limit = 766;
    else if (pick == 2) limit = 1023;
    else                limit = $urandom_range(20, 400);
    pick = $urandom_range(0, 5);
    if (pick == 0)      fov = '0;
    else if (pick == 1) fov = '1;
    else                fov = CFG_DATA_W'($urandom);
    write_register(REG_FRAME_WIDTH, with_junk(CFG_DATA_W'(width), DIM_CFG_W));
    write_register(REG_FRAME_HEIGHT, with_junk(CFG_DATA_W'($urandom_range(0, 4)), DIM_CFG_W));
    write_register(REG_VIEW_ANGLE, fov);
    write_register(REG_REF_FIRST, with_junk(CFG_DATA_W'($urandom_range(0, 255)), CHAN_W));
    write_register(REG_REF_SECOND, with_junk(CFG_DATA_W'($urandom_range(0, 255)), CHAN_W));
    write_register(REG_REF_THIRD, with_junk(CFG_DATA_W'($urandom_range(0, 255)), CHAN_W));
    write_register(REG_MATCH_LIMIT, with_junk(CFG_DATA_W'(limit), LIMIT_W));
    if ($urandom_range(0, 3) == 0) write_register(REG_UNMAPPED, CFG_DATA_W'($urandom));
  endtask

  // Result sink: random stalls, or one long hold-off on request
  initial begin : result_sink
    int stall_left;
    stall_left    = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_request  = 1'b0;
        m_axis_tready = 1'b1;
      end else begin
        if (rx_stalls_on && stall_left == 0 && $urandom_range(0, 3) == 0)
          stall_left = idle_length();
        if (stall_left > 0) begin
          stall_left--;
          m_axis_tready = 1'b0;
        end else begin
          m_axis_tready = 1'b1;
        end
      end
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin : result_check
    ckcc_result_t          want;
    logic                  got_found;
    logic [ANGLE_W-1:0]    got_angle;
    logic [COUNT_OUT_W-1:0] got_count;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_found = m_axis_tdata[0];
      got_angle = m_axis_tdata[ANGLE_W:1];
      got_count = m_axis_tdata[ANGLE_W+COUNT_OUT_W:ANGLE_W+1];
      if (expected_frames.size() == 0) begin
        report_mismatch("unexpected result, found", longint'(got_found), 0);
      end else begin
        want = expected_frames.pop_front();
        if (got_found !== want.found)
          report_mismatch("found", longint'(got_found), longint'(want.found));
        if (got_angle !== want.angle)
          report_mismatch("steer_angle_q12", longint'($signed(got_angle)),
                          longint'($signed(want.angle)));
        if (got_count !== want.count)
          report_mismatch("matched_pixels", longint'(got_count), longint'(want.count));
        if (m_axis_tdata[OUT_DATA_W-1:OUT_BITS] !== '0)
          report_mismatch("padding", longint'(m_axis_tdata[OUT_DATA_W-1:OUT_BITS]), 0);
      end
      frames_checked++;
    end
  end

  // Count cycles without any transaction on either stream
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("watchdog: %0d cycles without a transaction", WATCHDOG_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    opening_row_t row;
    int           random_sent;
    int           burst;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    quiet_cycles  = 0;
    stream_busy   = 1'b0;
    hold_request  = 1'b0;
    tx_gaps_on    = 1'b1;
    rx_stalls_on  = 1'b1;

    // Reset values of the predictor
    key_width      = RST_FRAME_WIDTH;
    key_height     = RST_FRAME_HEIGHT;
    key_fov        = RST_VIEW_ANGLE;
    key_ref_first  = RST_REF_FIRST;
    key_ref_second = RST_REF_SECOND;
    key_ref_third  = RST_REF_THIRD;
    key_limit      = RST_MATCH_LIMIT;
    col_pos        = 0;
    row_pos        = 0;
    col_sum        = 0;
    hit_count      = 0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Walk the opening rows
    foreach (OPENING_ROWS[i]) begin
      row = OPENING_ROWS[i];
      case (row.kind)
        ROW_WRITE:       write_register(row.addr, row.value);
        ROW_PIXEL_KNOWN: send_pixel(row.pixel, 1'b1, row.want);
        default:         send_pixel(row.pixel, 1'b0, NO_RESULT);
      endcase
    end

    // Oversize width with every pixel matching, height written with junk bits
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b1;
    write_register(REG_FRAME_WIDTH, 16'd2047);
    write_register(REG_FRAME_HEIGHT, 16'hF801);
    write_register(REG_VIEW_ANGLE, 16'd4096);
    write_register(REG_MATCH_LIMIT, 16'd766);
    repeat (WIDE_PIXELS) send_pixel(make_pixel(1'b0), 1'b0, NO_RESULT);

    // Shrink the width in the middle of a row: the row closes and the angle saturates
    write_register(REG_FRAME_WIDTH, 16'd1);
    send_pixel(make_pixel(1'b0), 1'b0, NO_RESULT);

    // Oversize height, one pixel per row, then a height change closes the frame
    tx_gaps_on = 1'b1;
    write_register(REG_FRAME_HEIGHT, 16'd2047);
    write_register(REG_MATCH_LIMIT, 16'd120);
    repeat (TALL_PIXELS) send_pixel(make_pixel($urandom_range(0, 1)), 1'b0, NO_RESULT);
    write_register(REG_FRAME_HEIGHT, 16'd1);
    send_pixel(make_pixel($urandom_range(0, 1)), 1'b0, NO_RESULT);

    // Hold the result side off while two-pixel frames keep arriving
    write_register(REG_FRAME_WIDTH, 16'd2);
    write_register(REG_FRAME_HEIGHT, 16'd1);
    write_register(REG_MATCH_LIMIT, 16'd766);
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    hold_request = 1'b1;
    repeat (40) send_pixel(make_pixel(1'b1), 1'b0, NO_RESULT);

    // Random phases: new key settings, then a burst that may end mid-frame
    random_sent = 0;
    while (random_sent < RANDOM_PIXELS) begin
      draw_key_settings();
      tx_gaps_on   = $urandom_range(0, 1);
      rx_stalls_on = $urandom_range(0, 1);
      burst        = $urandom_range(30, 90);
      repeat (burst) send_pixel(make_pixel($urandom_range(0, 1)), 1'b0, NO_RESULT);
      random_sent += burst;
    end

    // Let the last results out
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("summary: %0d pixels, %0d frame results, %0d register writes, %0d errors",
             pixels_sent, frames_checked, register_writes, mismatches);
    $display("summary: zero, unit and oversize frames, mid-row resize, %0d-cycle hold",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
